// ===== sv/rns_pkg.sv =====
// Shared types and constants of the rate network relaxation sweep.
package rns_pkg;

	localparam logic [2:0] REQ_WR_EXC = 3'd0;
	localparam logic [2:0] REQ_WR_INH = 3'd1;
	localparam logic [2:0] REQ_LOAD   = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_SWEEP  = 3'd4;

	localparam logic [1:0] REG_LEAK_GAIN    = 2'd0;
	localparam logic [1:0] REG_STEP_SIZE    = 2'd1;
	localparam logic [1:0] REG_DEPRESSED    = 2'd2;
	localparam logic [1:0] REG_NEURON_COUNT = 2'd3;

	localparam logic [15:0] LEAK_GAIN_RESET    = 16'd4096;
	localparam logic [15:0] STEP_SIZE_RESET    = 16'd655;
	localparam logic [6:0]  NEURON_COUNT_RESET = 7'd64;
	localparam logic [15:0] RATE_RESET         = 16'd32768;

	localparam int          EXP_SPAN  = 2048;
	localparam logic [31:0] EXP_RATIO = 32'd4278222805;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [15:0] value;
	} req_t;

	typedef struct packed {
		logic [5:0]         neuron_index;
		logic [15:0]        rate;
		logic signed [15:0] activity;
		logic               saturated;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [15:0] leak_gain;
		logic [15:0] step_size;
		logic        depressed_mode;
		logic [6:0]  neuron_count;
	} cfg_t;

endpackage

// ===== sv/rate_network_relaxation_sweep.sv =====
// Top level: weight and neuron stores, shared multiplier and sweep sequencer.
//
//  channel   signals                                   transfer at
//  config    psel penable pwrite paddr pwdata prdata   psel & penable & pwrite & pready
//  request   start busy req                            start & !busy
//  result    result_valid result                       every cycle result_valid is high
//
//  Write and load requests finish when accepted; a read registers its result in S_READ.
//  A sweep over n neurons issues one multiply per weight on the single shared
//  multiplier, then runs the per-neuron update steps for each neuron.
//  After reset all NEURONS*NEURONS entries of both weight memories are zeroed one
//  entry a cycle, with busy high; config writes are taken meanwhile.
//  Results appear one a cycle at most and cannot be stalled.
module rate_network_relaxation_sweep #(
	parameter int NEURONS             = 64,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  rns_pkg::req_t     req,
	output logic              result_valid,
	output rns_pkg::res_t     result
);

	localparam int AW = $clog2(NEURONS);
	localparam int CW = $clog2(NEURONS + 1);
	localparam int WA = $clog2(NEURONS * NEURONS);
	localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int PW = 12 + $clog2(SIGMOID_TABLE_DEPTH + 1);

	typedef logic [15:0] sig_tab_t [SIGMOID_TABLE_DEPTH];

	function automatic sig_tab_t build_sig();
		sig_tab_t    t;
		logic [32:0] e [rns_pkg::EXP_SPAN + 1];
		logic [64:0] pr;
		logic [33:0] den;
		logic [49:0] p;
		int          c;
		int          m;
		e[0] = 33'h1_0000_0000;
		for (int k = 0; k < rns_pkg::EXP_SPAN; k++) begin
			pr = 65'(e[k]) * 65'(rns_pkg::EXP_RATIO) + 65'h8000_0000;
			e[k + 1] = 33'(pr >> 32);
		end
		for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
			c = (i * 4096) / SIGMOID_TABLE_DEPTH - 2048;
			m = (c < 0) ? -c : c;
			if (m > rns_pkg::EXP_SPAN) m = rns_pkg::EXP_SPAN;
			den = 34'h1_0000_0000 + 34'(e[m]);
			p = (50'h1_0000_0000_0000 + 50'(den >> 1)) / 50'(den);
			if (c >= 0) t[i] = (p > 50'd65535) ? 16'hFFFF : p[15:0];
			else        t[i] = 16'(50'd65536 - p);
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig();

	function automatic logic [15:0] sig_of(input logic signed [15:0] a);
		logic [11:0]   u;
		logic [PW-1:0] pr;
		if (a < -16'sd2048)     u = 12'd0;
		else if (a > 16'sd2047) u = 12'hFFF;
		else                    u = 12'(a + 16'sd2048);
		pr = PW'(u) * PW'(SIGMOID_TABLE_DEPTH);
		return SIG_TAB[pr[12 +: IW]];
	endfunction

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_READ  = 10'b00_0000_0100,
		S_MAC   = 10'b00_0000_1000,
		S_LEAK  = 10'b00_0001_0000,
		S_DIFF  = 10'b00_0010_0000,
		S_MLO   = 10'b00_0100_0000,
		S_MHI   = 10'b00_1000_0000,
		S_SUM   = 10'b01_0000_0000,
		S_UPD   = 10'b10_0000_0000
	} state_t;

	rns_pkg::cfg_t cfg;

	rns_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [15:0]        w_mem [NEURONS * NEURONS];
	logic [15:0]        h_mem [NEURONS * NEURONS];
	logic signed [15:0] act_mem [NEURONS];
	logic [15:0]        rate_mem [NEURONS];

	state_t              state_q;
	logic [WA-1:0]       clr_q;
	logic [AW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       n_q;
	logic                p1_q;
	logic                p2_q;
	logic signed [41:0]  acc_q;
	logic signed [41:0]  d_q;
	logic signed [38:0]  prod_q;
	logic signed [38:0]  lo_q;
	logic signed [23:0]  inc_q;
	logic signed [15:0]  act_q;
	logic [5:0]          rd_row_q;
	logic [NEURONS-1:0]  act_vld_q;
	logic [NEURONS-1:0]  rate_vld_q;
	logic                res_vld_q;
	rns_pkg::res_t       res_q;

	logic [15:0]         w_rd_q;
	logic [15:0]         h_rd_q;
	logic signed [15:0]  act_rd_q;
	logic [15:0]         rate_rd_q;
	logic                act_rv_q;
	logic                rate_rv_q;

	logic                accept;
	logic                row_ok;
	logic                col_ok;
	logic [AW-1:0]       row_a;
	logic [AW-1:0]       col_a;
	logic [CW-1:0]       eff_n;
	logic                issue;

	logic                w_we;
	logic                h_we;
	logic [WA-1:0]       w_waddr;
	logic [15:0]         w_wdata;
	logic [WA-1:0]       w_raddr;
	logic                n_we;
	logic [AW-1:0]       n_waddr;
	logic signed [15:0]  n_wact;
	logic [15:0]         n_wrate;
	logic [AW-1:0]       act_raddr;
	logic [AW-1:0]       rate_raddr;

	logic signed [21:0]  ma;
	logic signed [16:0]  mb;
	logic signed [16:0]  wdiff;
	logic [15:0]         rate_eff;
	logic signed [15:0]  act_eff;
	logic signed [59:0]  sum60;
	logic signed [24:0]  next_act;
	logic signed [15:0]  new_act;
	logic                new_sat;
	logic [15:0]         new_rate;
	logic                last_n;

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;
	assign row_a  = req.row_index[AW-1:0];
	assign col_a  = req.col_index[AW-1:0];
	assign row_ok = int'(req.row_index) < NEURONS;
	assign col_ok = int'(req.col_index) < NEURONS;
	assign issue  = (state_q == S_MAC) && (j_q != n_q);
	assign last_n = (CW'(i_q) == n_q - CW'(1));

	always_comb begin
		if (cfg.neuron_count == 7'd0)               eff_n = CW'(1);
		else if (int'(cfg.neuron_count) > NEURONS) eff_n = CW'(NEURONS);
		else                                        eff_n = CW'(cfg.neuron_count);
	end

	// weight store ports
	always_comb begin
		w_we    = 1'b0;
		h_we    = 1'b0;
		w_waddr = WA'(WA'(row_a) * WA'(NEURONS)) + WA'(col_a);
		w_wdata = req.value;
		if (state_q == S_CLEAR) begin
			w_we    = 1'b1;
			h_we    = 1'b1;
			w_waddr = clr_q;
			w_wdata = 16'd0;
		end else if (accept && row_ok && col_ok) begin
			w_we = (req.req_type == rns_pkg::REQ_WR_EXC);
			h_we = (req.req_type == rns_pkg::REQ_WR_INH);
		end
		w_raddr = WA'(WA'(i_q) * WA'(NEURONS)) + WA'(j_q[AW-1:0]);
	end

	always_ff @(posedge clk) begin
		if (w_we) w_mem[w_waddr] <= w_wdata;
		w_rd_q <= w_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we) h_mem[w_waddr] <= w_wdata;
		h_rd_q <= h_mem[w_raddr];
	end

	// neuron store ports
	always_comb begin
		if (state_q == S_UPD) begin
			n_we    = 1'b1;
			n_waddr = i_q;
			n_wact  = new_act;
			n_wrate = new_rate;
		end else begin
			n_we    = accept && row_ok && (req.req_type == rns_pkg::REQ_LOAD);
			n_waddr = row_a;
			n_wact  = req.value;
			n_wrate = sig_of(req.value);
		end
		act_raddr  = accept ? row_a : i_q;
		rate_raddr = accept ? row_a : j_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (n_we) act_mem[n_waddr] <= n_wact;
		act_rd_q <= act_mem[act_raddr];
	end

	always_ff @(posedge clk) begin
		if (n_we) rate_mem[n_waddr] <= n_wrate;
		rate_rd_q <= rate_mem[rate_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_vld_q  <= '0;
			rate_vld_q <= '0;
			act_rv_q   <= 1'b0;
			rate_rv_q  <= 1'b0;
		end else begin
			if (n_we) begin
				act_vld_q[n_waddr]  <= 1'b1;
				rate_vld_q[n_waddr] <= 1'b1;
			end
			act_rv_q  <= act_vld_q[act_raddr];
			rate_rv_q <= rate_vld_q[rate_raddr];
		end
	end

	assign rate_eff = rate_rv_q ? rate_rd_q : rns_pkg::RATE_RESET;
	assign act_eff  = act_rv_q ? act_rd_q : 16'sd0;

	// shared multiplier operands
	always_comb begin
		wdiff = cfg.depressed_mode ? (17'(signed'(w_rd_q)) - 17'(signed'(h_rd_q)))
		                           : 17'(signed'(w_rd_q));
		ma = 22'(wdiff);
		mb = signed'({1'b0, rate_eff});
		priority case (1'b1)
			state_q[4]: begin
				ma = 22'(act_eff);
				mb = signed'({1'b0, cfg.leak_gain});
			end
			state_q[6]: begin
				ma = signed'({1'b0, d_q[20:0]});
				mb = signed'({1'b0, cfg.step_size});
			end
			state_q[7]: begin
				ma = 22'(signed'(d_q[41:21]));
				mb = signed'({1'b0, cfg.step_size});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 39'(ma * mb);
	end

	always_comb begin
		sum60    = (60'(prod_q) <<< 21) + 60'(lo_q) + (60'sd1 <<< 35);
		next_act = 25'(act_q) + 25'(inc_q);
		new_sat  = 1'b0;
		new_act  = next_act[15:0];
		if (next_act > 25'sd32767) begin
			new_act = 16'sd32767;
			new_sat = 1'b1;
		end else if (next_act < -25'sd32768) begin
			new_act = -16'sd32768;
			new_sat = 1'b1;
		end
		new_rate = sig_of(new_act);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			p1_q      <= 1'b0;
			p2_q      <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			p1_q      <= issue;
			p2_q      <= p1_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WA'(1);
					if (clr_q == WA'(NEURONS * NEURONS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						rd_row_q <= req.row_index;
						if (req.req_type == rns_pkg::REQ_READ) begin
							state_q <= S_READ;
						end else if (req.req_type == rns_pkg::REQ_SWEEP) begin
							n_q     <= eff_n;
							i_q     <= '0;
							j_q     <= '0;
							acc_q   <= '0;
							state_q <= S_MAC;
						end
					end
				end
				S_READ: begin
					res_vld_q          <= 1'b1;
					res_q.neuron_index <= rd_row_q;
					res_q.saturated    <= 1'b0;
					res_q.last         <= 1'b1;
					if (int'(rd_row_q) < NEURONS) begin
						res_q.rate     <= rate_eff;
						res_q.activity <= act_eff;
					end else begin
						res_q.rate     <= 16'd0;
						res_q.activity <= 16'sd0;
					end
					state_q <= S_IDLE;
				end
				S_MAC: begin
					if (issue) j_q <= j_q + CW'(1);
					if (p2_q) acc_q <= acc_q + 42'(prod_q);
					if (!issue && !p1_q && !p2_q) state_q <= S_LEAK;
				end
				S_LEAK: begin
					act_q   <= act_eff;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					d_q     <= acc_q - (42'(prod_q) <<< 8);
					state_q <= S_MLO;
				end
				S_MLO: begin
					state_q <= S_MHI;
				end
				S_MHI: begin
					lo_q    <= prod_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					inc_q   <= sum60[59:36];
					state_q <= S_UPD;
				end
				S_UPD: begin
					res_vld_q          <= 1'b1;
					res_q.neuron_index <= 6'(i_q);
					res_q.rate         <= new_rate;
					res_q.activity     <= new_act;
					res_q.saturated    <= new_sat;
					res_q.last         <= last_n;
					if (last_n) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + AW'(1);
						j_q     <= '0;
						acc_q   <= '0;
						state_q <= S_MAC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

endmodule

// ===== sv/rns_apb_regs.sv =====
// Configuration registers behind the APB-style port.
module rns_apb_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output rns_pkg::cfg_t     cfg
);

	rns_pkg::cfg_t cfg_q;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leak_gain      <= rns_pkg::LEAK_GAIN_RESET;
			cfg_q.step_size      <= rns_pkg::STEP_SIZE_RESET;
			cfg_q.depressed_mode <= 1'b0;
			cfg_q.neuron_count   <= rns_pkg::NEURON_COUNT_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				rns_pkg::REG_LEAK_GAIN:    cfg_q.leak_gain      <= pwdata[15:0];
				rns_pkg::REG_STEP_SIZE:    cfg_q.step_size      <= pwdata[15:0];
				rns_pkg::REG_DEPRESSED:    cfg_q.depressed_mode <= pwdata[0];
				rns_pkg::REG_NEURON_COUNT: cfg_q.neuron_count   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rns_pkg::REG_LEAK_GAIN:    prdata = {16'd0, cfg_q.leak_gain};
			rns_pkg::REG_STEP_SIZE:    prdata = {16'd0, cfg_q.step_size};
			rns_pkg::REG_DEPRESSED:    prdata = {31'd0, cfg_q.depressed_mode};
			rns_pkg::REG_NEURON_COUNT: prdata = {25'd0, cfg_q.neuron_count};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

// ===== test/tb_rate_network_relaxation_sweep.sv =====
// Testbench of the rate network relaxation sweep: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_rate_network_relaxation_sweep;

	localparam int NEURONS    = 64;
	localparam int SIG_DEPTH  = 256;
	localparam int CYCLE_CAP  = 3000000;
	localparam int PHASE_ITEMS = 17;

	typedef struct {
		rns_pkg::req_t r;
		bit            typed;
		rns_pkg::res_t e;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          psel, penable, pwrite;
	logic [3:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;
	logic          start;
	logic          busy;
	rns_pkg::req_t req;
	logic          result_valid;
	rns_pkg::res_t result;

	logic signed [15:0] exc_w [NEURONS*NEURONS];
	logic signed [15:0] inh_w [NEURONS*NEURONS];
	int                 act_m [NEURONS];
	logic [15:0]        rate_m [NEURONS];
	logic [15:0]        sig_lut [SIG_DEPTH];
	logic [15:0]        leak_r, step_r;
	logic               depr_r;
	logic [6:0]         count_r;

	rns_pkg::res_t pending_rates[$];
	dir_row_t      dir_rows[$];
	int            errors, cycles, items_sent, results_seen, sweeps_sent, sats_seen;
	bit            idle_en;

	rate_network_relaxation_sweep #(.NEURONS(NEURONS), .SIGMOID_TABLE_DEPTH(SIG_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic [15:0] sigmoid_of(int a);
		int idx;
		if (a < -2048) a = -2048;
		if (a > 2047) a = 2047;
		idx = ((a + 2048) * SIG_DEPTH) >> 12;
		if (idx >= SIG_DEPTH) idx = SIG_DEPTH - 1;
		return sig_lut[idx];
	endfunction

	function automatic void build_sigmoid();
		longint unsigned e [rns_pkg::EXP_SPAN+1];
		longint unsigned den, p;
		int c, m;
		e[0] = 64'd1 << 32;
		for (int k = 0; k < rns_pkg::EXP_SPAN; k++)
			e[k+1] = (e[k] * 64'(rns_pkg::EXP_RATIO) + (64'd1 << 31)) >> 32;
		for (int k = 0; k < SIG_DEPTH; k++) begin
			c = (k * 4096) / SIG_DEPTH - 2048;
			m = c < 0 ? -c : c;
			if (m > rns_pkg::EXP_SPAN) m = rns_pkg::EXP_SPAN;
			den = (64'd1 << 32) + e[m];
			p = ((64'd1 << 48) + den / 2) / den;
			if (c >= 0) sig_lut[k] = p > 65535 ? 16'hFFFF : p[15:0];
			else sig_lut[k] = 16'(65536 - p);
		end
	endfunction

	function automatic void net_clear();
		for (int k = 0; k < NEURONS*NEURONS; k++) begin
			exc_w[k] = '0;
			inh_w[k] = '0;
		end
		for (int k = 0; k < NEURONS; k++) begin
			act_m[k] = 0;
			rate_m[k] = rns_pkg::RATE_RESET;
		end
		leak_r = rns_pkg::LEAK_GAIN_RESET;
		step_r = rns_pkg::STEP_SIZE_RESET;
		depr_r = 1'b0;
		count_r = rns_pkg::NEURON_COUNT_RESET;
	endfunction

	// advance the network model by one accepted request, queue the rates it emits
	function automatic void net_update(rns_pkg::req_t r, bit typed, rns_pkg::res_t typed_res);
		rns_pkg::res_t o;
		longint acc, d, nxt;
		int n;
		bit sat;
		case (r.req_type)
			rns_pkg::REQ_WR_EXC: exc_w[r.row_index*NEURONS + r.col_index] = r.value;
			rns_pkg::REQ_WR_INH: inh_w[r.row_index*NEURONS + r.col_index] = r.value;
			rns_pkg::REQ_LOAD: begin
				act_m[r.row_index] = r.value;
				rate_m[r.row_index] = sigmoid_of(r.value);
			end
			rns_pkg::REQ_READ: begin
				o.neuron_index = r.row_index;
				o.rate = rate_m[r.row_index];
				o.activity = 16'(act_m[r.row_index]);
				o.saturated = 1'b0;
				o.last = 1'b1;
				pending_rates.push_back(typed ? typed_res : o);
			end
			rns_pkg::REQ_SWEEP: begin
				n = count_r;
				if (n < 1) n = 1;
				if (n > NEURONS) n = NEURONS;
				for (int i = 0; i < n; i++) begin
					acc = 0;
					for (int j = 0; j < n; j++) begin
						acc += longint'(exc_w[i*NEURONS + j]) * longint'(rate_m[j]);
						if (depr_r)
							acc -= longint'(inh_w[i*NEURONS + j]) * longint'(rate_m[j]);
					end
					d = acc - longint'(leak_r) * longint'(act_m[i]) * 256;
					nxt = act_m[i] + ((d * longint'(step_r) + (64'sd1 <<< 35)) >>> 36);
					sat = 1'b0;
					if (nxt > 32767) begin
						nxt = 32767;
						sat = 1'b1;
					end else if (nxt < -32768) begin
						nxt = -32768;
						sat = 1'b1;
					end
					act_m[i] = int'(nxt);
					rate_m[i] = sigmoid_of(act_m[i]);
					o.neuron_index = 6'(i);
					o.rate = rate_m[i];
					o.activity = 16'(act_m[i]);
					o.saturated = sat;
					o.last = (i == n - 1);
					pending_rates.push_back(o);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_req(rns_pkg::req_t r, bit typed, rns_pkg::res_t typed_res);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		net_update(r, typed, typed_res);
		items_sent++;
		if (r.req_type == rns_pkg::REQ_SWEEP) sweeps_sent++;
		if (idle_en && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			rns_pkg::REG_LEAK_GAIN: leak_r = val[15:0];
			rns_pkg::REG_STEP_SIZE: step_r = val[15:0];
			rns_pkg::REG_DEPRESSED: depr_r = val[0];
			default:                count_r = val[6:0];
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_rates.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
	endtask

	function automatic rns_pkg::req_t rand_req(int span);
		rns_pkg::req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.req_type = pick < 30 ? rns_pkg::REQ_WR_EXC : pick < 45 ? rns_pkg::REQ_WR_INH :
			pick < 65 ? rns_pkg::REQ_LOAD : pick < 80 ? rns_pkg::REQ_READ :
			pick < 92 ? rns_pkg::REQ_SWEEP : 3'($urandom_range(5, 7));
		r.row_index = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, span - 1));
		r.col_index = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, span - 1));
		case ($urandom_range(0, 3))
			0: r.value = 16'($urandom);
			1: r.value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: r.value = 16'($signed($urandom_range(0, 4096)) - 2048);
		endcase
		return r;
	endfunction

	function automatic void add_row(logic [2:0] t, int row, int col, int val, bit typed,
			int e_rate, int e_act);
		dir_row_t d;
		d.r.req_type = t;
		d.r.row_index = 6'(row);
		d.r.col_index = 6'(col);
		d.r.value = 16'(val);
		d.typed = typed;
		d.e = '{neuron_index: 6'(row), rate: 16'(e_rate), activity: 16'(e_act),
			saturated: 1'b0, last: 1'b1};
		dir_rows.push_back(d);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_rates.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		rns_pkg::res_t x;
		if (arst_n && result_valid) begin
			results_seen++;
			if (result.saturated) sats_seen++;
			if (pending_rates.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				x = pending_rates.pop_front();
				if (result.neuron_index !== x.neuron_index) begin
					$display("%0t: neuron_index exp %0d got %0d", $time, x.neuron_index,
						result.neuron_index);
					errors++;
				end
				if (result.rate !== x.rate) begin
					$display("%0t: rate exp %0d got %0d", $time, x.rate, result.rate);
					errors++;
				end
				if (result.activity !== x.activity) begin
					$display("%0t: activity exp %0d got %0d", $time, x.activity, result.activity);
					errors++;
				end
				if (result.saturated !== x.saturated) begin
					$display("%0t: saturated exp %0b got %0b", $time, x.saturated,
						result.saturated);
					errors++;
				end
				if (result.last !== x.last) begin
					$display("%0t: last exp %0b got %0b", $time, x.last, result.last);
					errors++;
				end
			end
		end
	end

	initial begin
		int counts [7];
		int leaks  [7];
		int steps  [7];
		int span;
		counts = '{4, 1, 0, 2, 127, 8, 64};
		leaks  = '{0, 65535, 4096, 1234, 65535, 0, 4096};
		steps  = '{65535, 0, 655, 65535, 40000, 65535, 655};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		cycles = 0;
		idle_en = 1'b1;
		build_sigmoid();
		net_clear();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_row(rns_pkg::REQ_READ, 0, 0, 0, 1, 32768, 0);
		add_row(rns_pkg::REQ_READ, 63, 0, 0, 1, 32768, 0);
		add_row(rns_pkg::REQ_WR_EXC, 0, 0, 32767, 0, 0, 0);
		add_row(rns_pkg::REQ_WR_EXC, 63, 63, -32768, 0, 0, 0);
		add_row(rns_pkg::REQ_WR_EXC, 1, 0, 4096, 0, 0, 0);
		add_row(rns_pkg::REQ_WR_INH, 0, 63, -32768, 0, 0, 0);
		add_row(rns_pkg::REQ_WR_INH, 63, 0, 32767, 0, 0, 0);
		add_row(rns_pkg::REQ_LOAD, 1, 0, 32767, 0, 0, 0);
		add_row(rns_pkg::REQ_LOAD, 2, 0, -32768, 0, 0, 0);
		add_row(rns_pkg::REQ_LOAD, 3, 0, 2047, 0, 0, 0);
		add_row(rns_pkg::REQ_LOAD, 4, 0, -2049, 0, 0, 0);
		add_row(rns_pkg::REQ_READ, 1, 0, 0, 0, 0, 0);
		add_row(rns_pkg::REQ_READ, 2, 0, 0, 0, 0, 0);
		add_row(rns_pkg::REQ_READ, 3, 0, 0, 0, 0, 0);
		add_row(3'd5, 5, 5, 100, 0, 0, 0);
		add_row(3'd6, 6, 6, -100, 0, 0, 0);
		add_row(3'd7, 7, 7, 1, 0, 0, 0);
		add_row(rns_pkg::REQ_SWEEP, 0, 0, 0, 0, 0, 0);
		add_row(rns_pkg::REQ_READ, 63, 0, 0, 0, 0, 0);
		add_row(rns_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
		foreach (dir_rows[k]) send_req(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].e);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			cfg_write(rns_pkg::REG_LEAK_GAIN, leaks[ph]);
			cfg_write(rns_pkg::REG_STEP_SIZE, steps[ph]);
			cfg_write(rns_pkg::REG_DEPRESSED, ph % 2);
			cfg_write(rns_pkg::REG_NEURON_COUNT, counts[ph]);
			span = counts[ph] < 1 ? 1 : counts[ph] > NEURONS ? NEURONS : counts[ph];
			idle_en = (ph != 3);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_req(rand_req(span), 0, '0);
			send_req('{req_type: rns_pkg::REQ_SWEEP, row_index: 0, col_index: 0, value: 0},
				0, '0);
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d requests, %0d sweeps, %0d results checked (%0d saturated)",
			items_sent, sweeps_sent, results_seen, sats_seen);
		$display("Swept leak and step at both extremes, both modes, counts 0 to 127");
		if (errors == 0 && pending_rates.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
